[sv/bmpd_pkg.sv]
// bmpd_pkg: types and fixed constants shared by the BMP stream decoder.
// Result record passed from the parser front to the output back, queue status.
// No dependencies.
package bmpd_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_FILE_HDR = 3'd0,
    ERR_OFFSET   = 3'd1,
    ERR_INFO_HDR = 3'd2,
    ERR_FORMAT   = 3'd3,
    ERR_SIZE     = 3'd4
  } err_t;

  // One queued result; on pixel beats image_height/bottom_up carry the flip info.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] pixel;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        bottom_up;
    logic        no_alpha;
    logic [30:0] horiz_res;
    logic [30:0] vert_res;
    err_t        error_code;
    logic        final_res;
  } entry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  localparam logic [15:0] BMP_MAGIC         = 16'h4D42;
  localparam logic [31:0] INFO_HDR_SIZE     = 32'd40;
  localparam logic [31:0] HDR_BYTES         = 32'd54;
  localparam logic [31:0] IDX_FSIZE_DONE    = 32'd5;
  localparam logic [31:0] IDX_FILE_HDR_DONE = 32'd13;
  localparam logic [31:0] IDX_INFO_HDR_DONE = 32'd53;
  localparam logic [15:0] BITS_24           = 16'd24;
  localparam logic [15:0] BITS_32           = 16'd32;
  localparam logic [15:0] ONE_PLANE         = 16'd1;
  localparam logic [31:0] COMP_RGB          = 32'd0;
  localparam logic [31:0] COMP_BITFIELDS    = 32'd3;
  localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;

endpackage

[sv/bmp_stream_decoder.sv]
// bmp_stream_decoder: top level of the streaming BMP (24/32 bpp) decoder.
// Instantiates bmpd_front, bmpd_fifo and bmpd_back; depends on bmpd_pkg.
//
// Input: one file byte per beat on in_data_byte, in_end_of_file marks the
// last byte of a file, after which the decoder rearms for the next file.
// Output: at most one result per input byte - a header beat (kind 1) after
// byte 53, BGRA pixel beats (kind 0) with column and top-down row, or an
// error beat (kind 2, final_res set), after which the rest of the file is
// dropped. Pixels of bottom-up files come out with their rows already
// remapped, so the sink writes them straight to place.
// Throughput: one byte per clock, sustained, with the sink always ready.
// Path: a result is written into the queue on the edge that takes its byte,
// then loaded into the output register that drives out_valid.
// Sink stall: results wait in a two-entry queue behind the output register;
// in_ready falls only when that queue is full, and rises as soon as the
// output register drains.
// Reset (rst_n low, synchronous): parser back to header parsing, queue and
// output register empty. No clearing pass; usable the cycle after.
module bmp_stream_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_pixel,
  output logic [11:0] out_column,
  output logic [11:0] out_row,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic        out_bottom_up,
  output logic        out_no_alpha,
  output logic [30:0] out_horiz_res,
  output logic [30:0] out_vert_res,
  output logic [2:0]  out_error_code,
  output logic        out_final_res
);
  import bmpd_pkg::*;

  q_stat_t q_stat;
  entry_t  push_entry, pop_entry;
  logic    push, pop;

  bmpd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .q_stat         (q_stat),
    .push           (push),
    .push_entry     (push_entry)
  );

  bmpd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  bmpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_entry          (pop_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_pixel        (out_pixel),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_bottom_up    (out_bottom_up),
    .out_no_alpha     (out_no_alpha),
    .out_horiz_res    (out_horiz_res),
    .out_vert_res     (out_vert_res),
    .out_error_code   (out_error_code),
    .out_final_res    (out_final_res)
  );

endmodule

[sv/bmpd_front.sv]
// bmpd_front: byte-level parser. Collects and checks the BMP headers, tracks
// skip/pixel/padding phases and pushes one result record per producing byte.
// Depends on bmpd_pkg.
module bmpd_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_file,
  input  bmpd_pkg::q_stat_t q_stat,
  output logic             push,
  output bmpd_pkg::entry_t push_entry
);
  import bmpd_pkg::*;

  localparam int WBITS = $clog2(MAX_WIDTH + 1);
  localparam int HBITS = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = WBITS + 3;
  localparam int PW    = HBITS + SW;
  localparam int CW    = (PW > 32) ? PW : 32;

  typedef enum logic [2:0] {
    PH_HEADER, PH_SKIP, PH_PIXELS, PH_PAD, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [3:0] {
    F_NONE, F_MAGIC, F_FSIZE, F_RSVD, F_OFF, F_HSIZE, F_WIDTH, F_HEIGHT,
    F_PLANES, F_COMP, F_CSIZE, F_HRES, F_VRES, F_NCOL, F_NIMP
  } fld_t;

  function automatic fld_t fld_of(input logic [5:0] a);
    case (a) inside
      [6'd0:6'd1]:   return F_MAGIC;
      [6'd2:6'd5]:   return F_FSIZE;
      [6'd6:6'd9]:   return F_RSVD;
      [6'd10:6'd13]: return F_OFF;
      [6'd14:6'd17]: return F_HSIZE;
      [6'd18:6'd21]: return F_WIDTH;
      [6'd22:6'd25]: return F_HEIGHT;
      [6'd26:6'd29]: return F_PLANES;
      [6'd30:6'd33]: return F_COMP;
      [6'd34:6'd37]: return F_CSIZE;
      [6'd38:6'd41]: return F_HRES;
      [6'd42:6'd45]: return F_VRES;
      [6'd46:6'd49]: return F_NCOL;
      [6'd50:6'd53]: return F_NIMP;
      default:       return F_NONE;
    endcase
  endfunction

  phase_t            phase_r, phase_nxt;
  logic [31:0]       idx_r, idx_nxt;
  logic [31:0]       fs_r, fs_nxt;
  logic [31:0]       off_r, off_nxt;
  logic [23:0]       acc_r, acc_nxt;
  logic [1:0]        bip_r, bip_nxt;
  logic [WBITS-1:0]  col_r, col_nxt;
  logic [HBITS-1:0]  row_r, row_nxt;
  logic [1:0]        padcnt_r, padcnt_nxt;

  logic [15:0]       magic_r;
  logic [31:0]       rsvd_r, hsize_r, width_r, height_r, planes_r, comp_r;
  logic [31:0]       csize_r, hres_r, vres_r, ncol_r, nimp_r;

  logic [31:0]       len_r, habs_r;
  logic              wbig_r, hbig_r;
  logic [SW-1:0]     stride_r;
  logic [PW-1:0]     prod_r;

  logic              accept, eof, bpp4, last_byte, ec_hit, bad2, bad3;
  logic [7:0]        b;
  fld_t              sel;
  logic [31:0]       fs_sh, off_sh, nimp_sh;
  logic [32:0]       cnt33;
  logic [WBITS-1:0]  wl, col_inc;
  logic [HBITS-1:0]  row_inc;
  logic [WBITS+1:0]  w3;
  logic [1:0]        pad_amt;
  err_t              ec_val;
  entry_t            ent;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data_byte;
  assign eof      = in_end_of_file;
  assign sel      = (phase_r == PH_HEADER) ? fld_of(idx_r[5:0]) : F_NONE;
  assign fs_sh    = (sel == F_FSIZE) ? {b, fs_r[31:8]} : fs_r;
  assign off_sh   = (sel == F_OFF) ? {b, off_r[31:8]} : off_r;
  assign nimp_sh  = (sel == F_NIMP) ? {b, nimp_r[31:8]} : nimp_r;
  assign cnt33    = {1'b0, idx_r} + 33'd1;
  assign bpp4     = planes_r[31:16] != BITS_24;
  assign wl       = width_r[WBITS-1:0];
  assign w3       = {2'b00, wl} + {1'b0, wl, 1'b0};
  assign pad_amt  = bpp4 ? 2'd0 : width_r[1:0];
  assign col_inc  = col_r + WBITS'(1);
  assign row_inc  = row_r + HBITS'(1);
  assign last_byte = bpp4 ? (bip_r == 2'd3) : (bip_r == 2'd2);

  assign bad2 = planes_r[15:0] != ONE_PLANE || width_r[31] || width_r == '0 ||
                height_r == '0 || hsize_r != INFO_HDR_SIZE || ncol_r != '0 ||
                nimp_sh != '0 || hres_r[31] || vres_r[31];
  assign bad3 = (planes_r[31:16] != BITS_24 && planes_r[31:16] != BITS_32) ||
                (comp_r != COMP_RGB && comp_r != COMP_BITFIELDS) ||
                (csize_r != '0 && csize_r != len_r) || wbig_r || hbig_r;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    fs_nxt     = fs_r;
    off_nxt    = off_r;
    acc_nxt    = acc_r;
    bip_nxt    = bip_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    padcnt_nxt = padcnt_r;
    push       = 1'b0;
    ent        = '0;
    ec_hit     = 1'b0;
    ec_val     = ERR_FILE_HDR;
    if (accept) begin
      idx_nxt = (idx_r == '1) ? idx_r : idx_r + 32'd1;
      if (phase_r != PH_ERROR) begin
        fs_nxt  = fs_sh;
        off_nxt = off_sh;
        if ((phase_r != PH_HEADER || idx_r >= IDX_FSIZE_DONE) && idx_r >= fs_sh) begin
          ec_hit = 1'b1;
        end else begin
          unique case (phase_r)
            PH_HEADER: begin
              if (idx_r == IDX_FILE_HDR_DONE) begin
                if (magic_r != BMP_MAGIC || rsvd_r != '0 || off_sh < HDR_BYTES) begin
                  ec_hit = 1'b1;
                end else if (off_sh >= fs_sh) begin
                  ec_hit = 1'b1;
                  ec_val = ERR_OFFSET;
                end
              end else if (idx_r == IDX_INFO_HDR_DONE) begin
                if (bad2) begin
                  ec_hit = 1'b1;
                  ec_val = ERR_INFO_HDR;
                end else if (bad3) begin
                  ec_hit = 1'b1;
                  ec_val = ERR_FORMAT;
                end else if (CW'(len_r) != CW'(prod_r)) begin
                  ec_hit = 1'b1;
                  ec_val = ERR_SIZE;
                end else begin
                  push             = 1'b1;
                  ent.kind         = KIND_HEADER;
                  ent.image_width  = width_r[12:0];
                  ent.image_height = habs_r[12:0];
                  ent.bottom_up    = !height_r[31];
                  ent.no_alpha     = !bpp4;
                  ent.horiz_res    = hres_r[30:0];
                  ent.vert_res     = vres_r[30:0];
                  phase_nxt        = (off_sh <= HDR_BYTES) ? PH_PIXELS : PH_SKIP;
                end
              end
            end
            PH_SKIP: begin
              if (cnt33 >= {1'b0, off_r}) phase_nxt = PH_PIXELS;
            end
            PH_PIXELS: begin
              if (!last_byte) begin
                case (bip_r)
                  2'd0:    acc_nxt = {16'h0000, b};
                  2'd1:    acc_nxt[15:8] = b;
                  default: acc_nxt[23:16] = b;
                endcase
                bip_nxt = bip_r + 2'd1;
              end else begin
                push             = 1'b1;
                ent.kind         = KIND_PIXEL;
                ent.pixel        = bpp4 ? {b, acc_r} : {ALPHA_OPAQUE, b, acc_r[15:0]};
                ent.column       = 12'(col_r);
                ent.row          = 12'(row_r);
                ent.image_height = habs_r[12:0];
                ent.bottom_up    = !height_r[31];
                acc_nxt          = '0;
                bip_nxt          = 2'd0;
                col_nxt          = col_inc;
                if (col_inc == wl) begin
                  col_nxt = '0;
                  row_nxt = row_inc;
                  if (row_inc == habs_r[HBITS-1:0]) begin
                    phase_nxt     = PH_DONE;
                    ent.final_res = 1'b1;
                  end else if (pad_amt != 2'd0) begin
                    phase_nxt  = PH_PAD;
                    padcnt_nxt = pad_amt;
                  end
                end
              end
            end
            PH_PAD: begin
              padcnt_nxt = padcnt_r - 2'd1;
              if (padcnt_r == 2'd1) phase_nxt = PH_PIXELS;
            end
            default: ;
          endcase
        end
        if (ec_hit) begin
          push           = 1'b1;
          ent            = '0;
          ent.kind       = KIND_ERROR;
          ent.error_code = ec_val;
          ent.final_res  = 1'b1;
          phase_nxt      = PH_ERROR;
        end
        if (eof && phase_nxt != PH_ERROR &&
            (phase_nxt == PH_HEADER || cnt33 != {1'b0, fs_sh})) begin
          push           = 1'b1;
          ent            = '0;
          ent.kind       = KIND_ERROR;
          ent.error_code = ERR_FILE_HDR;
          ent.final_res  = 1'b1;
        end
      end
      if (eof) begin
        phase_nxt  = PH_HEADER;
        idx_nxt    = '0;
        fs_nxt     = '0;
        off_nxt    = '0;
        acc_nxt    = '0;
        bip_nxt    = 2'd0;
        col_nxt    = '0;
        row_nxt    = '0;
        padcnt_nxt = 2'd0;
      end
    end
  end

  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      idx_r    <= '0;
      fs_r     <= '0;
      off_r    <= '0;
      acc_r    <= '0;
      bip_r    <= 2'd0;
      col_r    <= '0;
      row_r    <= '0;
      padcnt_r <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      fs_r     <= fs_nxt;
      off_r    <= off_nxt;
      acc_r    <= acc_nxt;
      bip_r    <= bip_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      padcnt_r <= padcnt_nxt;
    end
  end

  // header words, little-endian shift-in
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (sel)
        F_MAGIC:  magic_r  <= {b, magic_r[15:8]};
        F_RSVD:   rsvd_r   <= {b, rsvd_r[31:8]};
        F_HSIZE:  hsize_r  <= {b, hsize_r[31:8]};
        F_WIDTH:  width_r  <= {b, width_r[31:8]};
        F_HEIGHT: height_r <= {b, height_r[31:8]};
        F_PLANES: planes_r <= {b, planes_r[31:8]};
        F_COMP:   comp_r   <= {b, comp_r[31:8]};
        F_CSIZE:  csize_r  <= {b, csize_r[31:8]};
        F_HRES:   hres_r   <= {b, hres_r[31:8]};
        F_VRES:   vres_r   <= {b, vres_r[31:8]};
        F_NCOL:   ncol_r   <= {b, ncol_r[31:8]};
        F_NIMP:   nimp_r   <= {b, nimp_r[31:8]};
        default:  ;
      endcase
    end
  end

  // derived geometry, settles well before the last info header byte
  always_ff @(posedge clk) begin
    len_r    <= fs_r - off_r;
    habs_r   <= height_r[31] ? (32'd0 - height_r) : height_r;
    wbig_r   <= width_r > 32'(MAX_WIDTH);
    hbig_r   <= habs_r > 32'(MAX_HEIGHT);
    stride_r <= bpp4 ? {1'b0, wl, 2'b00} : ((SW'(w3) + SW'(3)) & ~SW'(3));
    prod_r   <= PW'(habs_r[HBITS-1:0]) * PW'(stride_r);
  end

endmodule

[sv/bmpd_fifo.sv]
// bmpd_fifo: two-entry result queue between parser front and output back.
// Depends on bmpd_pkg.
module bmpd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bmpd_pkg::entry_t  push_entry,
  input  logic              pop,
  output bmpd_pkg::entry_t  pop_entry,
  output bmpd_pkg::q_stat_t q_stat
);
  import bmpd_pkg::*;

  entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign q_stat.avail = cnt_r != '0;
  assign pop_entry    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

endmodule

[sv/bmpd_back.sv]
// bmpd_back: output register stage. Pops queued records, applies the row flip
// for bottom-up images and clears fields that do not belong to the beat's kind.
// Depends on bmpd_pkg.
module bmpd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bmpd_pkg::q_stat_t q_stat,
  input  bmpd_pkg::entry_t  q_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [31:0]       out_pixel,
  output logic [11:0]       out_column,
  output logic [11:0]       out_row,
  output logic [12:0]       out_image_width,
  output logic [12:0]       out_image_height,
  output logic              out_bottom_up,
  output logic              out_no_alpha,
  output logic [30:0]       out_horiz_res,
  output logic [30:0]       out_vert_res,
  output logic [2:0]        out_error_code,
  output logic              out_final_res
);
  import bmpd_pkg::*;

  logic   out_valid_r, out_valid_nxt;
  entry_t res_r, fmt;

  assign pop           = q_stat.avail && (!out_valid_r || out_ready);
  assign out_valid_nxt = pop || (out_valid_r && !out_ready);

  always_comb begin
    fmt = '0;
    unique case (q_entry.kind)
      KIND_PIXEL: begin
        fmt.kind      = KIND_PIXEL;
        fmt.pixel     = q_entry.pixel;
        fmt.column    = q_entry.column;
        fmt.row       = q_entry.bottom_up ?
                        (q_entry.image_height[11:0] - 12'd1 - q_entry.row) : q_entry.row;
        fmt.final_res = q_entry.final_res;
      end
      KIND_HEADER: begin
        fmt.kind         = KIND_HEADER;
        fmt.image_width  = q_entry.image_width;
        fmt.image_height = q_entry.image_height;
        fmt.bottom_up    = q_entry.bottom_up;
        fmt.no_alpha     = q_entry.no_alpha;
        fmt.horiz_res    = q_entry.horiz_res;
        fmt.vert_res     = q_entry.vert_res;
      end
      KIND_ERROR: begin
        fmt.kind       = KIND_ERROR;
        fmt.error_code = q_entry.error_code;
        fmt.final_res  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (pop) res_r <= fmt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = res_r.kind;
  assign out_pixel        = res_r.pixel;
  assign out_column       = res_r.column;
  assign out_row          = res_r.row;
  assign out_image_width  = res_r.image_width;
  assign out_image_height = res_r.image_height;
  assign out_bottom_up    = res_r.bottom_up;
  assign out_no_alpha     = res_r.no_alpha;
  assign out_horiz_res    = res_r.horiz_res;
  assign out_vert_res     = res_r.vert_res;
  assign out_error_code   = res_r.error_code;
  assign out_final_res    = res_r.final_res;

endmodule

[sv/bmpd_checker.sv]
// bmpd_checker: port-level assertions for bmp_stream_decoder, bound to the top.
// Depends on bmpd_pkg.
module bmpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_pixel,
  input logic        out_final_res
);
  import bmpd_pkg::*;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result visible after reset");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_final_res)
    else $error("error beat without final_res");

  a_hdr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_HEADER |-> out_pixel == '0 && !out_final_res)
    else $error("header beat carries pixel data or final_res");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a byte two edges earlier");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_kind))
    else $error("stalled result changed");

endmodule

bind bmp_stream_decoder bmpd_checker u_chk (.*);
